/* hw/rtl/kmp_pkg.sv */
// ----------------------------------------------------------------------------
// kmp_pkg
// shared types, codes and reset values for the keypad menu panel controller
// ----------------------------------------------------------------------------
package kmp_pkg;

  // default parameter values
  localparam int unsigned COUNT_WRAP_DEF   = 10000;
  localparam int unsigned LETTER_COUNT_DEF = 3;
  localparam int unsigned DIGIT_COUNT      = 10;

  // field widths
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned COUNT_W   = 14;
  localparam int unsigned LED_W     = 8;
  localparam int unsigned LETTER_W  = 2;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned PERIOD_W  = 8;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned IN_DAT_W  = 8;
  localparam int unsigned OUT_DAT_W = 40;

  // key codes
  localparam logic [KEY_W-1:0] KEY_NONE       = 4'd0;
  localparam logic [KEY_W-1:0] KEY_PARAM_UP   = 4'd2;
  localparam logic [KEY_W-1:0] KEY_MODE_DOWN  = 4'd4;
  localparam logic [KEY_W-1:0] KEY_MODE_UP    = 4'd6;
  localparam logic [KEY_W-1:0] KEY_PARAM_DOWN = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TENTH_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LED_PERIOD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd2;

  // reset values
  localparam logic [PERIOD_W-1:0]  TENTH_PERIOD_RST = 8'd5;
  localparam logic [PERIOD_W-1:0]  LED_PERIOD_RST   = 8'd25;
  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = 16'd500;
  localparam logic [LED_W-1:0]     LED_PATTERN_RST  = 8'h7F;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LETTER = 2'd1,
    MODE_INT    = 2'd2,
    MODE_FRAC   = 2'd3
  } menu_mode_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic                pad;
    logic [KEY_W-1:0]    shown_key;
    logic                redraw;
    logic [DIGIT_W-1:0]  fraction_digit;
    logic [DIGIT_W-1:0]  integer_digit;
    logic [LETTER_W-1:0] letter_index;
    menu_mode_t          menu_mode;
    logic [LED_W-1:0]    leds;
    logic [COUNT_W-1:0]  count;
  } result_t;

endpackage

/* hw/rtl/keypad_menu_panel_controller.sv */
// ----------------------------------------------------------------------------
// keypad_menu_panel_controller
// per-tick stopwatch, led rotator and keypad menu with display redraw request
// ----------------------------------------------------------------------------
// Each input transaction on in_* is one display tick carrying the key code
// held in that tick (0 = no key). Each tick produces exactly one output
// transaction on out_* with the stopwatch, led pattern, menu state, a redraw
// flag and the echoed key, all as they stand after the tick.
// A tick accepted at an edge shows its result on out_tdata with out_tvalid
// high right after that edge. Throughput is one tick per cycle while the
// receiver does not stall; the tick state and the result register are updated
// in the same edge, with a single combinational pass in between.
// When the receiver stalls, the result register holds and in_tready drops
// until the result is taken; in_tready is high again in the cycle the result
// is taken, so no bubble is inserted.
// The cfg_* port writes tenth_period (0), led_period (1) and idle_timeout (2)
// at any edge with cfg_we high; write only while no tick is in flight.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// counters and menu, loads led pattern 0x7F and makes the first tick redraw.
// ----------------------------------------------------------------------------
module keypad_menu_panel_controller
  import kmp_pkg::*;
#(
  parameter int unsigned COUNT_WRAP   = COUNT_WRAP_DEF,
  parameter int unsigned LETTER_COUNT = LETTER_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DAT_W-1:0]  in_tdata,   // key[3:0], zero fill
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_DAT_W-1:0] out_tdata,  // count[13:0], leds[21:14],
                                           // menu_mode[23:22], letter_index[25:24],
                                           // integer_digit[29:26],
                                           // fraction_digit[33:30], redraw[34],
                                           // shown_key[38:35], zero fill
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int unsigned SW_W = (COUNT_WRAP > 1) ? $clog2(COUNT_WRAP) : 1;
  localparam int unsigned LT_W = (LETTER_COUNT > 1) ? $clog2(LETTER_COUNT) : 1;
  localparam logic [SW_W-1:0]    SW_LAST     = SW_W'(COUNT_WRAP - 1);
  localparam logic [LT_W-1:0]    LETTER_LAST = LT_W'(LETTER_COUNT - 1);
  localparam logic [DIGIT_W-1:0] DIGIT_LAST  = DIGIT_W'(DIGIT_COUNT - 1);

  // configuration
  logic [PERIOD_W-1:0]  tenth_period_r;
  logic [PERIOD_W-1:0]  led_period_r;
  logic [TIMEOUT_W-1:0] idle_timeout_r;

  // tick state
  logic [PERIOD_W-1:0]  tenth_cnt_r, tenth_cnt_nxt;
  logic [PERIOD_W-1:0]  led_cnt_r, led_cnt_nxt;
  logic [TIMEOUT_W-1:0] idle_cnt_r, idle_cnt_nxt;
  logic [SW_W-1:0]      stopwatch_r, stopwatch_nxt;
  logic [LED_W-1:0]     led_pattern_r, led_pattern_nxt;
  logic [KEY_W-1:0]     prev_key_r;
  menu_mode_t           mode_r, mode_nxt;
  logic [LT_W-1:0]      letter_r, letter_nxt;
  logic [DIGIT_W-1:0]   int_digit_r, int_digit_nxt;
  logic [DIGIT_W-1:0]   frac_digit_r, frac_digit_nxt;
  logic                 redraw_pend_r, redraw_pend_nxt;

  // result register
  logic                 out_valid_r;
  result_t              result_r, result_nxt;

  logic                 in_acc;
  logic [KEY_W-1:0]     key;
  logic                 redraw;
  logic [31:0]          sw_ext;
  logic [31:0]          letter_ext;

  assign key        = in_tdata[KEY_W-1:0];
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tenth_period_r <= TENTH_PERIOD_RST;
      led_period_r   <= LED_PERIOD_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TENTH_PERIOD: tenth_period_r <= cfg_wdata[PERIOD_W-1:0];
        REG_LED_PERIOD:   led_period_r   <= cfg_wdata[PERIOD_W-1:0];
        REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic                 tenth_fire;
    logic                 led_fire;
    logic                 timeout;
    logic                 key_edge;
    logic [PERIOD_W-1:0]  tenth_inc;
    logic [PERIOD_W-1:0]  led_inc;
    logic [TIMEOUT_W-1:0] idle_inc;

    tenth_inc       = tenth_cnt_r + 1'b1;
    led_inc         = led_cnt_r + 1'b1;
    idle_inc        = idle_cnt_r + 1'b1;
    tenth_fire      = (tenth_inc >= tenth_period_r);
    led_fire        = (led_inc >= led_period_r);
    timeout         = (idle_inc >= idle_timeout_r);
    tenth_cnt_nxt   = tenth_fire ? '0 : tenth_inc;
    led_cnt_nxt     = led_fire ? '0 : led_inc;
    idle_cnt_nxt    = timeout ? '0 : idle_inc;
    key_edge        = (key != prev_key_r);

    mode_nxt        = mode_r;
    letter_nxt      = letter_r;
    int_digit_nxt   = int_digit_r;
    frac_digit_nxt  = frac_digit_r;
    redraw_pend_nxt = redraw_pend_r;

    // key handling
    if (mode_r == MODE_IDLE && key != KEY_NONE) begin
      mode_nxt        = MODE_LETTER;
      redraw_pend_nxt = 1'b1;
    end else if (key_edge) begin
      case (key)
        KEY_MODE_DOWN: begin
          mode_nxt        = (mode_r == MODE_LETTER) ? MODE_FRAC
                                                    : menu_mode_t'(mode_r - 2'd1);
          redraw_pend_nxt = 1'b1;
        end
        KEY_MODE_UP: begin
          mode_nxt        = (mode_r == MODE_FRAC) ? MODE_LETTER
                                                  : menu_mode_t'(mode_r + 2'd1);
          redraw_pend_nxt = 1'b1;
        end
        KEY_PARAM_DOWN: begin
          case (mode_r)
            MODE_LETTER: letter_nxt = (letter_r == '0) ? LETTER_LAST : letter_r - 1'b1;
            MODE_INT:    int_digit_nxt = (int_digit_r == '0) ? DIGIT_LAST
                                                            : int_digit_r - 1'b1;
            MODE_FRAC:   frac_digit_nxt = (frac_digit_r == '0) ? DIGIT_LAST
                                                              : frac_digit_r - 1'b1;
            default: ;
          endcase
          redraw_pend_nxt = 1'b1;
        end
        KEY_PARAM_UP: begin
          case (mode_r)
            MODE_LETTER: letter_nxt = (letter_r == LETTER_LAST) ? '0 : letter_r + 1'b1;
            MODE_INT:    int_digit_nxt = (int_digit_r == DIGIT_LAST) ? '0
                                                                   : int_digit_r + 1'b1;
            MODE_FRAC:   frac_digit_nxt = (frac_digit_r == DIGIT_LAST) ? '0
                                                                     : frac_digit_r + 1'b1;
            default: ;
          endcase
          redraw_pend_nxt = 1'b1;
        end
        default: ;
      endcase
    end

    // stopwatch and leds
    stopwatch_nxt = stopwatch_r;
    if (tenth_fire && key == KEY_NONE) begin
      stopwatch_nxt = (stopwatch_r == SW_LAST) ? '0 : stopwatch_r + 1'b1;
    end
    led_pattern_nxt = led_fire ? {led_pattern_r[0], led_pattern_r[LED_W-1:1]}
                               : led_pattern_r;

    // redraw and timeout
    redraw = redraw_pend_nxt || timeout;
    if (redraw) begin
      redraw_pend_nxt = 1'b0;
      idle_cnt_nxt    = '0;
      if (timeout) begin
        mode_nxt = MODE_IDLE;
      end
    end

    sw_ext     = 32'(stopwatch_nxt);
    letter_ext = 32'(letter_nxt);

    result_nxt                = '0;
    result_nxt.count          = sw_ext[COUNT_W-1:0];
    result_nxt.leds           = led_pattern_nxt;
    result_nxt.menu_mode      = mode_nxt;
    result_nxt.letter_index   = letter_ext[LETTER_W-1:0];
    result_nxt.integer_digit  = int_digit_nxt;
    result_nxt.fraction_digit = frac_digit_nxt;
    result_nxt.redraw         = redraw;
    result_nxt.shown_key      = key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tenth_cnt_r   <= '0;
      led_cnt_r     <= '0;
      idle_cnt_r    <= '0;
      stopwatch_r   <= '0;
      led_pattern_r <= LED_PATTERN_RST;
      prev_key_r    <= KEY_NONE;
      mode_r        <= MODE_IDLE;
      letter_r      <= '0;
      int_digit_r   <= '0;
      frac_digit_r  <= '0;
      redraw_pend_r <= 1'b1;
    end else if (in_acc) begin
      tenth_cnt_r   <= tenth_cnt_nxt;
      led_cnt_r     <= led_cnt_nxt;
      idle_cnt_r    <= idle_cnt_nxt;
      stopwatch_r   <= stopwatch_nxt;
      led_pattern_r <= led_pattern_nxt;
      prev_key_r    <= key;
      mode_r        <= mode_nxt;
      letter_r      <= letter_nxt;
      int_digit_r   <= int_digit_nxt;
      frac_digit_r  <= frac_digit_nxt;
      redraw_pend_r <= redraw_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      result_r <= result_nxt;
    end
  end

  // any menu mode change is reported with a redraw
  a_mode_change_redraws: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (mode_nxt != mode_r) |=> result_r.redraw)
    else $error("menu mode changed without redraw");

  // stopwatch stays below its wrap value
  a_stopwatch_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (stopwatch_r <= SW_LAST))
    else $error("stopwatch out of range");

  // edited parameters stay in range
  a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (letter_r <= LETTER_LAST) && (int_digit_r <= DIGIT_LAST)
               && (frac_digit_r <= DIGIT_LAST))
    else $error("menu parameter out of range");

  // a timeout always leaves the menu idle
  a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (idle_cnt_r + 1'b1 >= idle_timeout_r) |=> (mode_r == MODE_IDLE))
    else $error("timeout did not return to idle");

endmodule

/* verif/keypad_menu_panel_controller_tb.sv */
// ----------------------------------------------------------------------------
// keypad_menu_panel_controller_tb
// self-checking testbench for the keypad menu panel controller
// ----------------------------------------------------------------------------
// Ticks are streamed into the block with random gaps and random output stalls.
// A tick-level model kept in the testbench predicts the stopwatch, led
// rotation, menu state, redraw flag and echoed key for every accepted tick.
// Each output transaction is compared field by field with the oldest
// prediction. Directed tests walk the menu, the idle timeout and the period
// extremes, then random keypad sessions under three idle profiles, a long
// output stall and drained pauses before every configuration change.
// ----------------------------------------------------------------------------
module keypad_menu_panel_controller_tb;
  import kmp_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_LEN    = 250;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DAT_W-1:0]  in_tdata   = '0;   // key[3:0], zero fill
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DAT_W-1:0] out_tdata;         // count, leds, menu_mode, letter_index,
                                           // integer_digit, fraction_digit,
                                           // redraw, shown_key, zero fill
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata  = '0;

  keypad_menu_panel_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // panel model state
  logic [PERIOD_W-1:0]  tenth_per;
  logic [PERIOD_W-1:0]  led_per;
  logic [TIMEOUT_W-1:0] idle_limit;
  logic [PERIOD_W-1:0]  tenth_cnt;
  logic [PERIOD_W-1:0]  led_cnt;
  logic [TIMEOUT_W-1:0] idle_cnt;
  logic [COUNT_W-1:0]   watch;
  logic [LED_W-1:0]     led_pat;
  logic [KEY_W-1:0]     last_key;
  menu_mode_t           menu;
  logic [LETTER_W-1:0]  letter_sel;
  logic [DIGIT_W-1:0]   int_val;
  logic [DIGIT_W-1:0]   frac_val;
  bit                   redraw_due;

  result_t     panel_results_due [$];
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic bit prescale_tick(inout logic [15:0] ctr, input logic [15:0] period);
    ctr = ctr + 16'd1;
    if (ctr >= period) begin
      ctr = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t advance_panel(input logic [KEY_W-1:0] key);
    result_t    res;
    bit         tenth_fire;
    bit         led_fire;
    bit         timed_out;
    logic [15:0] c;
    c = tenth_cnt;
    tenth_fire = prescale_tick(c, 16'(tenth_per));
    tenth_cnt = c[PERIOD_W-1:0];
    c = led_cnt;
    led_fire = prescale_tick(c, 16'(led_per));
    led_cnt = c[PERIOD_W-1:0];
    c = idle_cnt;
    timed_out = prescale_tick(c, idle_limit);
    idle_cnt = c;

    // any key wakes the menu from idle, other keys act on a new press only
    if (menu == MODE_IDLE && key != KEY_NONE) begin
      menu = MODE_LETTER;
      redraw_due = 1'b1;
    end else if (key != last_key) begin
      case (key)
        KEY_MODE_DOWN: begin
          case (menu)
            MODE_LETTER: menu = MODE_FRAC;
            MODE_INT:    menu = MODE_LETTER;
            default:     menu = MODE_INT;
          endcase
          redraw_due = 1'b1;
        end
        KEY_MODE_UP: begin
          case (menu)
            MODE_LETTER: menu = MODE_INT;
            MODE_INT:    menu = MODE_FRAC;
            default:     menu = MODE_LETTER;
          endcase
          redraw_due = 1'b1;
        end
        KEY_PARAM_DOWN: begin
          case (menu)
            MODE_LETTER: letter_sel = (letter_sel == 0) ? LETTER_W'(LETTER_COUNT_DEF - 1)
                                                        : letter_sel - 1'b1;
            MODE_INT:    int_val = (int_val == 0) ? DIGIT_W'(DIGIT_COUNT - 1) : int_val - 1'b1;
            MODE_FRAC:   frac_val = (frac_val == 0) ? DIGIT_W'(DIGIT_COUNT - 1)
                                                    : frac_val - 1'b1;
            default: ;
          endcase
          redraw_due = 1'b1;
        end
        KEY_PARAM_UP: begin
          case (menu)
            MODE_LETTER: letter_sel = (letter_sel == LETTER_COUNT_DEF - 1) ? '0
                                                                           : letter_sel + 1'b1;
            MODE_INT:    int_val = (int_val == DIGIT_COUNT - 1) ? '0 : int_val + 1'b1;
            MODE_FRAC:   frac_val = (frac_val == DIGIT_COUNT - 1) ? '0 : frac_val + 1'b1;
            default: ;
          endcase
          redraw_due = 1'b1;
        end
        default: ;
      endcase
    end
    last_key = key;

    if (tenth_fire && key == KEY_NONE)
      watch = (watch == COUNT_WRAP_DEF - 1) ? '0 : watch + 1'b1;
    if (led_fire)
      led_pat = {led_pat[0], led_pat[LED_W-1:1]};

    res = '0;
    if (redraw_due || timed_out) begin
      redraw_due = 1'b0;
      if (timed_out)
        menu = MODE_IDLE;
      idle_cnt = '0;
      res.redraw = 1'b1;
    end
    res.count          = watch;
    res.leds           = led_pat;
    res.menu_mode      = menu;
    res.letter_index   = letter_sel;
    res.integer_digit  = int_val;
    res.fraction_digit = frac_val;
    res.shown_key      = key;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // scoreboard: check results first, then predict newly accepted ticks
  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata);
      if (panel_results_due.size() == 0) begin
        $error("output transaction with no tick pending");
        mismatches++;
      end else begin
        want = panel_results_due.pop_front();
        check_field("count", want.count, got.count);
        check_field("leds", want.leds, got.leds);
        check_field("menu_mode", want.menu_mode, got.menu_mode);
        check_field("letter_index", want.letter_index, got.letter_index);
        check_field("integer_digit", want.integer_digit, got.integer_digit);
        check_field("fraction_digit", want.fraction_digit, got.fraction_digit);
        check_field("redraw", want.redraw, got.redraw);
        check_field("shown_key", want.shown_key, got.shown_key);
        check_field("pad", want.pad, got.pad);
      end
    end
    if (rst_n && in_tvalid && in_tready)
      panel_results_due.push_back(advance_panel(in_tdata[KEY_W-1:0]));
  end

  // output side stalls
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = HOLD_LEN;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DAT_W'(key);
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (panel_results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_config(input logic [PERIOD_W-1:0] tenth, input logic [PERIOD_W-1:0] led,
                            input logic [TIMEOUT_W-1:0] timeout);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TENTH_PERIOD;
    cfg_wdata <= CFG_DAT_W'(tenth);
    @(posedge clk);
    cfg_index <= REG_LED_PERIOD;
    cfg_wdata <= CFG_DAT_W'(led);
    @(posedge clk);
    cfg_index <= REG_IDLE_TIMEOUT;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_we <= 1'b0;
    tenth_per  = tenth;
    led_per    = led;
    idle_limit = timeout;
  endtask

  task automatic send_keys(input logic [KEY_W-1:0] keys [$]);
    foreach (keys[i])
      send_tick(keys[i]);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] menu_keys [4];
    int unsigned r;
    menu_keys = '{KEY_PARAM_UP, KEY_MODE_DOWN, KEY_MODE_UP, KEY_PARAM_DOWN};
    r = $urandom_range(99);
    if (r < 65)
      return menu_keys[$urandom_range(3)];
    if (r < 92)
      return KEY_W'($urandom_range(1, 9));
    return KEY_W'($urandom_range(10, 15));
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(3))
      0:       return 8'd1;
      1:       return 8'd255;
      default: return PERIOD_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [TIMEOUT_W-1:0] pick_timeout();
    case ($urandom_range(7))
      0:       return 16'd1;
      1:       return 16'hFFFF;
      default: return TIMEOUT_W'($urandom_range(2, 60));
    endcase
  endfunction

  task automatic reset_panel_model();
    tenth_per  = TENTH_PERIOD_RST;
    led_per    = LED_PERIOD_RST;
    idle_limit = IDLE_TIMEOUT_RST;
    tenth_cnt  = '0;
    led_cnt    = '0;
    idle_cnt   = '0;
    watch      = '0;
    led_pat    = LED_PATTERN_RST;
    last_key   = KEY_NONE;
    menu       = MODE_IDLE;
    letter_sel = '0;
    int_val    = '0;
    frac_val   = '0;
    redraw_due = 1'b1;
  endtask

  // reset values, wake-up, mode stepping both ways, letter and integer wraps both ways, fraction wrap down
  task automatic test_menu_walk();
    send_keys('{KEY_NONE, KEY_NONE, 4'd9, 4'd9, KEY_MODE_UP, KEY_NONE, KEY_MODE_UP,
                KEY_MODE_UP, KEY_NONE, KEY_MODE_UP, KEY_MODE_DOWN, KEY_NONE, KEY_MODE_DOWN,
                KEY_PARAM_DOWN, KEY_PARAM_UP, KEY_PARAM_UP, KEY_NONE, KEY_PARAM_UP,
                KEY_MODE_DOWN, KEY_PARAM_DOWN, KEY_PARAM_UP, 4'd15, KEY_NONE, KEY_MODE_DOWN,
                KEY_PARAM_DOWN});
    wait_drained();
  endtask

  // timeout back to idle, and timeout winning over a key on the same tick
  task automatic test_idle_timeout();
    set_config(8'd3, 8'd2, 16'd4);
    send_keys('{KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE, KEY_MODE_UP,
                KEY_NONE, KEY_MODE_UP, KEY_PARAM_UP, KEY_NONE, KEY_NONE, KEY_NONE, KEY_NONE});
    wait_drained();
    set_config(8'd1, 8'd1, 16'd1);
    send_keys('{4'd5, KEY_MODE_UP, KEY_NONE, KEY_PARAM_UP, KEY_PARAM_DOWN, KEY_NONE});
    wait_drained();
  endtask

  // slowest periods, then a period lowered below the running count
  task automatic test_period_extremes();
    set_config(8'd255, 8'd255, 16'hFFFF);
    for (int i = 0; i < 40; i++)
      send_tick((i % 7 == 3) ? KEY_MODE_UP : KEY_NONE);
    wait_drained();
    set_config(8'd2, 8'd3, 16'd5);
    send_keys('{KEY_NONE, KEY_NONE, KEY_NONE, KEY_PARAM_UP, KEY_NONE, KEY_NONE});
    wait_drained();
  endtask

  // keypad sessions: presses held a few ticks, short releases, some long quiet runs
  task automatic test_random_sessions(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input int unsigned n_ticks);
    int unsigned stop_at;
    logic [KEY_W-1:0] key;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(15) == 0) begin
        wait_drained();
        set_config(pick_period(), pick_period(), pick_timeout());
      end
      key = pick_key();
      repeat ($urandom_range(1, 3))
        send_tick(key);
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(20, 80))
          send_tick(KEY_NONE);
      end else begin
        repeat ($urandom_range(0, 4))
          send_tick(KEY_NONE);
      end
    end
    wait_drained();
  endtask

  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(8'd4, 8'd6, 16'd30);
    rx_hold_req = 1'b1;
    for (int i = 0; i < 30; i++)
      send_tick((i % 4 == 0) ? pick_key() : KEY_NONE);
    wait_drained();
    for (int i = 0; i < 10; i++)
      send_tick(pick_key());
    wait_drained();
  endtask

  initial begin
    reset_panel_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_menu_walk();
    test_idle_timeout();
    test_period_extremes();
    test_random_sessions(14, 70, 220);
    test_random_sessions(70, 14, 220);
    test_random_sessions(0, 0, 220);
    test_output_stall();

    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && panel_results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
